FILE: hw/rtl/tshb_pkg.sv
// Shared constants, types and helpers of the torus spatial hash binning block.
package tshb_pkg;

  localparam int unsigned MAX_DIM  = 256;
  localparam int unsigned MAX_SPAN = 3;
  localparam int unsigned ID_WIDTH = 16;

  localparam int unsigned PID_W        = 16;
  localparam int unsigned COORD_W      = 32;
  localparam int unsigned RAD_W        = 31;
  localparam int unsigned SCALE_W      = 32;
  localparam int unsigned SCALE_HALF_W = SCALE_W / 2;
  localparam int unsigned NUM_W        = 9;
  localparam int unsigned CELL_W       = 16;
  localparam int unsigned CODE_W       = 4;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 32;

  localparam int unsigned HELD_ID_W = (ID_WIDTH < PID_W) ? ID_WIDTH : PID_W;
  localparam int unsigned DIM_W     = $clog2(MAX_DIM + 1);
  localparam int unsigned IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned SPAN_W    = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
  // coordinate minus radius minus origin, and the raw cell number, both fit here
  localparam int unsigned DIFF_W    = COORD_W + 2;

  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(65536);
  localparam logic [NUM_W-1:0]   NUM_RST   = NUM_W'(1);

  typedef logic [CODE_W-1:0] code_t;

  localparam code_t WRAP_NONE  = 4'd0;
  localparam code_t WRAP_LEFT  = 4'd1;
  localparam code_t WRAP_RIGHT = 4'd2;
  localparam code_t WRAP_DOWN  = 4'd3;
  localparam code_t WRAP_UP    = 4'd6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_ORIGIN = 3'd0,
    REG_Y_ORIGIN = 3'd1,
    REG_X_SCALE  = 3'd2,
    REG_Y_SCALE  = 3'd3,
    REG_NUM_ROWS = 3'd4,
    REG_NUM_COLS = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_origin;
    logic signed [COORD_W-1:0] y_origin;
    logic [SCALE_W-1:0]        x_scale;
    logic [SCALE_W-1:0]        y_scale;
    logic [DIM_W-1:0]          nr;
    logic [DIM_W-1:0]          nc;
  } cfg_t;

  typedef struct packed {
    logic [HELD_ID_W-1:0]       pid;
    logic [DIM_W-1:0]           nr;
    logic [DIM_W-1:0]           nc;
    logic [IDX_W-1:0]           row0;
    logic [IDX_W-1:0]           col0;
    logic [SPAN_W-1:0]          rcnt;
    logic [SPAN_W-1:0]          ccnt;
    code_t [MAX_SPAN-1:0]       vcode;
    code_t [MAX_SPAN-1:0]       hcode;
    logic                       clamped;
  } job_t;

  // zero counts as one, anything above the largest grid as the largest grid
  function automatic logic [DIM_W-1:0] dim_of(logic [NUM_W-1:0] n);
    logic [DIM_W-1:0] r;
    if (n == '0) begin
      r = DIM_W'(1);
    end else if (32'(n) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(n);
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/tshb_in_if.sv
// Particle input channel: valid/ready plus the particle fields.
interface tshb_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [tshb_pkg::PID_W-1:0]            particle_id;
  logic signed [tshb_pkg::COORD_W-1:0]   pos_x;
  logic signed [tshb_pkg::COORD_W-1:0]   pos_y;
  logic [tshb_pkg::RAD_W-1:0]            radius;

  modport source (output valid, particle_id, pos_x, pos_y, radius, input ready);
  modport sink   (input valid, particle_id, pos_x, pos_y, radius, output ready);
endinterface

FILE: hw/rtl/tshb_out_if.sv
// Cell output channel: valid/ready plus the cell fields.
interface tshb_out_if;
  logic                          valid;
  logic                          ready;
  logic [tshb_pkg::PID_W-1:0]    out_particle_id;
  logic [tshb_pkg::CELL_W-1:0]   cell_index;
  logic [tshb_pkg::CODE_W-1:0]   wrap_code;
  logic                          span_clamped;
  logic                          last;

  modport source (output valid, out_particle_id, cell_index, wrap_code, span_clamped, last,
                  input ready);
  modport sink   (input valid, out_particle_id, cell_index, wrap_code, span_clamped, last,
                  output ready);
endinterface

FILE: hw/rtl/tshb_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
interface tshb_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tshb_pkg::CFG_IDX_W-1:0]    index;
  logic [tshb_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/tshb_front.sv
// Front end: takes a particle, finds its raw cell range, clamps it and wraps the start.
module tshb_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  tshb_in_if.sink         in_i,
  input  tshb_pkg::cfg_t  cfg_i,
  output logic            push_o,
  output tshb_pkg::job_t  job_o,
  input  logic            full_i
);

  localparam int unsigned NUM_EDGES = 4;
  localparam logic [1:0]  E_R0 = 2'd0;
  localparam logic [1:0]  E_R1 = 2'd1;
  localparam logic [1:0]  E_C0 = 2'd2;
  localparam logic [1:0]  E_C1 = 2'd3;

  localparam int unsigned DW        = tshb_pkg::DIFF_W;
  localparam int unsigned PROD_W    = DW + tshb_pkg::SCALE_HALF_W + 1;
  localparam int unsigned SUM_SH    = tshb_pkg::SCALE_HALF_W;
  localparam int unsigned CMP_W     = DW + 1;
  localparam int unsigned MOD_BITS  = 8;
  localparam int unsigned MOD_STEPS = (DW - 1 + MOD_BITS - 1) / MOD_BITS;
  localparam int unsigned MOD_W     = MOD_STEPS * MOD_BITS;
  localparam int unsigned STEP_W    = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
  localparam int unsigned IW        = tshb_pkg::IDX_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_SUM   = 6'b000100,
    S_CLAMP = 6'b001000,
    S_MOD   = 6'b010000,
    S_PUSH  = 6'b100000
  } state_e;

  // remainder update, MSB first, one compare-subtract per bit
  function automatic logic [IW-1:0] mod_step(logic [IW-1:0] rem,
                                             logic [MOD_BITS-1:0] bits,
                                             logic [tshb_pkg::DIM_W-1:0] n);
    logic [IW:0]   t;
    logic [IW-1:0] r;
    r = rem;
    for (int b = MOD_BITS - 1; b >= 0; b--) begin
      t = {r, bits[b]};
      if (t >= (IW+1)'(n)) begin
        r = IW'(t - (IW+1)'(n));
      end else begin
        r = IW'(t);
      end
    end
    return r;
  endfunction

  state_e state_q, state_d;
  logic [1:0]        sel_q, sel_d;
  logic [STEP_W-1:0] step_q, step_d;

  logic signed [DW-1:0]     diff_q [NUM_EDGES];
  logic signed [DW-1:0]     diff_in [NUM_EDGES];
  logic signed [DW-1:0]     cell_q [NUM_EDGES];
  logic signed [PROD_W-1:0] mhi_q, mlo_q, sum_w;
  logic [tshb_pkg::SCALE_W-1:0] sc_w;

  logic [tshb_pkg::HELD_ID_W-1:0] pid_q;
  logic [tshb_pkg::DIM_W-1:0]     nr_q, nc_q;
  logic [IW-1:0]                  rrem_q, crem_q;
  logic [MOD_W-1:0]               rsh_q, csh_q;
  logic [tshb_pkg::SPAN_W-1:0]    rcnt_q, ccnt_q, rcnt_w, ccnt_w;
  tshb_pkg::code_t [tshb_pkg::MAX_SPAN-1:0] vcode_q, hcode_q, vcode_w, hcode_w;
  logic                           clamped_q, rclamp_w, cclamp_w;
  logic signed [CMP_W-1:0]        rspan_w, cspan_w;

  logic acc;

  assign in_i.ready = (state_q == S_IDLE);
  assign acc        = in_i.valid && in_i.ready;

  always_comb begin
    logic signed [DW-1:0] px, py, rad, xo, yo;
    px  = DW'(in_i.pos_x);
    py  = DW'(in_i.pos_y);
    rad = DW'(in_i.radius);
    xo  = DW'(cfg_i.x_origin);
    yo  = DW'(cfg_i.y_origin);
    diff_in[E_R0] = py - rad - yo;
    diff_in[E_R1] = py + rad - yo;
    diff_in[E_C0] = px - rad - xo;
    diff_in[E_C1] = px + rad - xo;
  end

  assign sc_w  = (sel_q == E_C0 || sel_q == E_C1) ? cfg_i.x_scale : cfg_i.y_scale;
  assign sum_w = mhi_q + (mlo_q >>> SUM_SH);

  // span clamp and side of each row and column of the box
  always_comb begin
    logic signed [CMP_W-1:0] v;
    rspan_w  = CMP_W'(cell_q[E_R1]) - CMP_W'(cell_q[E_R0]);
    cspan_w  = CMP_W'(cell_q[E_C1]) - CMP_W'(cell_q[E_C0]);
    rclamp_w = rspan_w > $signed(CMP_W'(tshb_pkg::MAX_SPAN - 1));
    cclamp_w = cspan_w > $signed(CMP_W'(tshb_pkg::MAX_SPAN - 1));
    rcnt_w   = rclamp_w ? tshb_pkg::SPAN_W'(tshb_pkg::MAX_SPAN - 1)
                        : tshb_pkg::SPAN_W'(rspan_w);
    ccnt_w   = cclamp_w ? tshb_pkg::SPAN_W'(tshb_pkg::MAX_SPAN - 1)
                        : tshb_pkg::SPAN_W'(cspan_w);
    for (int i = 0; i < tshb_pkg::MAX_SPAN; i++) begin
      v = CMP_W'(cell_q[E_R0]) + CMP_W'(i);
      if (v < 0) begin
        vcode_w[i] = tshb_pkg::WRAP_UP;
      end else if (v >= $signed(CMP_W'(nr_q))) begin
        vcode_w[i] = tshb_pkg::WRAP_DOWN;
      end else begin
        vcode_w[i] = tshb_pkg::WRAP_NONE;
      end
      v = CMP_W'(cell_q[E_C0]) + CMP_W'(i);
      if (v < 0) begin
        hcode_w[i] = tshb_pkg::WRAP_RIGHT;
      end else if (v >= $signed(CMP_W'(nc_q))) begin
        hcode_w[i] = tshb_pkg::WRAP_LEFT;
      end else begin
        hcode_w[i] = tshb_pkg::WRAP_NONE;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    step_d  = step_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          state_d = S_MUL;
          sel_d   = E_R0;
        end
      end
      S_MUL: state_d = S_SUM;
      S_SUM: begin
        if (sel_q == 2'(NUM_EDGES - 1)) begin
          state_d = S_CLAMP;
        end else begin
          sel_d   = sel_q + 2'd1;
          state_d = S_MUL;
        end
      end
      S_CLAMP: begin
        state_d = S_MOD;
        step_d  = '0;
      end
      S_MOD: begin
        if (step_q == STEP_W'(MOD_STEPS - 1)) begin
          state_d = S_PUSH;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      S_PUSH: begin
        if (!full_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      pid_q <= in_i.particle_id[tshb_pkg::HELD_ID_W-1:0];
      nr_q  <= cfg_i.nr;
      nc_q  <= cfg_i.nc;
      for (int k = 0; k < NUM_EDGES; k++) begin
        diff_q[k] <= diff_in[k];
      end
    end
    if (state_q == S_MUL) begin
      mhi_q <= PROD_W'(diff_q[sel_q])
             * PROD_W'($signed({1'b0, sc_w[tshb_pkg::SCALE_W-1 -: tshb_pkg::SCALE_HALF_W]}));
      mlo_q <= PROD_W'(diff_q[sel_q])
             * PROD_W'($signed({1'b0, sc_w[tshb_pkg::SCALE_HALF_W-1:0]}));
    end
    if (state_q == S_SUM) begin
      cell_q[sel_q] <= DW'(sum_w >>> SUM_SH);
    end
    if (state_q == S_CLAMP) begin
      rcnt_q    <= rcnt_w;
      ccnt_q    <= ccnt_w;
      clamped_q <= rclamp_w || cclamp_w;
      vcode_q   <= vcode_w;
      hcode_q   <= hcode_w;
      // the sign bit weighs minus one at the top of the expansion
      rrem_q    <= cell_q[E_R0][DW-1] ? IW'(nr_q - tshb_pkg::DIM_W'(1)) : '0;
      crem_q    <= cell_q[E_C0][DW-1] ? IW'(nc_q - tshb_pkg::DIM_W'(1)) : '0;
      rsh_q     <= MOD_W'(cell_q[E_R0]);
      csh_q     <= MOD_W'(cell_q[E_C0]);
    end
    if (state_q == S_MOD) begin
      rrem_q <= mod_step(rrem_q, rsh_q[MOD_W-1 -: MOD_BITS], nr_q);
      crem_q <= mod_step(crem_q, csh_q[MOD_W-1 -: MOD_BITS], nc_q);
      rsh_q  <= rsh_q << MOD_BITS;
      csh_q  <= csh_q << MOD_BITS;
    end
  end

  assign push_o = (state_q == S_PUSH) && !full_i;

  always_comb begin
    job_o         = '0;
    job_o.pid     = pid_q;
    job_o.nr      = nr_q;
    job_o.nc      = nc_q;
    job_o.row0    = rrem_q;
    job_o.col0    = crem_q;
    job_o.rcnt    = rcnt_q;
    job_o.ccnt    = ccnt_q;
    job_o.vcode   = vcode_q;
    job_o.hcode   = hcode_q;
    job_o.clamped = clamped_q;
  end

  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PUSH |-> ((IW+1)'(rrem_q) < (IW+1)'(nr_q)) &&
                          ((IW+1)'(crem_q) < (IW+1)'(nc_q)))
    else $error("wrapped start outside the grid");

  a_span_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PUSH |-> (32'(rcnt_q) <= tshb_pkg::MAX_SPAN - 1) &&
                          (32'(ccnt_q) <= tshb_pkg::MAX_SPAN - 1))
    else $error("span count beyond limit");

  a_start_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> (state_q == S_MUL) && (sel_q == E_R0))
    else $error("accepted item did not start at the first edge");

endmodule

FILE: hw/rtl/tshb_fifo.sv
// Short job queue between front and back end.
module tshb_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tshb_pkg::job_t  data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            avail_o,
  output tshb_pkg::job_t  data_o
);

  localparam int unsigned DEPTH = tshb_pkg::FIFO_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tshb_pkg::job_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign avail_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && avail_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: hw/rtl/tshb_back.sv
// Back end: walks the clamped box row by row and emits one cell per cycle while out_o is ready.
module tshb_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            avail_i,
  input  tshb_pkg::job_t  job_i,
  output logic            pop_o,
  tshb_out_if.source      out_o
);

  localparam int unsigned IW = tshb_pkg::IDX_W;
  localparam int unsigned DW = tshb_pkg::DIM_W;
  localparam int unsigned SW = tshb_pkg::SPAN_W;
  localparam int unsigned PW = IW + DW;

  function automatic logic [IW-1:0] wrap_inc(logic [IW-1:0] v, logic [DW-1:0] n);
    logic [IW:0] t;
    t = (IW+1)'(v) + (IW+1)'(1);
    return (t == (IW+1)'(n)) ? '0 : IW'(t);
  endfunction

  tshb_pkg::job_t job_q;
  logic           busy_q, busy_d;
  logic [SW-1:0]  i_q, i_d, j_q, j_d;
  logic [IW-1:0]  row_q, row_d, col_q, col_d;

  logic                           out_valid_q;
  logic [tshb_pkg::PID_W-1:0]     out_pid_q;
  logic [tshb_pkg::CELL_W-1:0]    out_cell_q;
  tshb_pkg::code_t                out_code_q;
  logic                           out_clamped_q, out_last_q;

  logic          adv, emit, last_cell;
  logic [PW-1:0] cell_full;

  assign pop_o     = !busy_q && avail_i;
  assign adv       = !out_valid_q || out_o.ready;
  assign emit      = busy_q && adv;
  assign last_cell = (i_q == job_q.rcnt) && (j_q == job_q.ccnt);
  assign cell_full = PW'(row_q) * PW'(job_q.nc) + PW'(col_q);

  always_comb begin
    busy_d = busy_q;
    i_d    = i_q;
    j_d    = j_q;
    row_d  = row_q;
    col_d  = col_q;
    if (pop_o) begin
      busy_d = 1'b1;
      i_d    = '0;
      j_d    = '0;
      row_d  = job_i.row0;
      col_d  = job_i.col0;
    end else if (emit) begin
      priority if (last_cell) begin
        busy_d = 1'b0;
      end else if (j_q == job_q.ccnt) begin
        j_d   = '0;
        col_d = job_q.col0;
        i_d   = i_q + SW'(1);
        row_d = wrap_inc(row_q, job_q.nr);
      end else begin
        j_d   = j_q + SW'(1);
        col_d = wrap_inc(col_q, job_q.nc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      i_q    <= i_d;
      j_q    <= j_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    col_q <= col_d;
    if (pop_o) begin
      job_q <= job_i;
    end
    if (emit) begin
      out_pid_q     <= tshb_pkg::PID_W'(job_q.pid);
      out_cell_q    <= tshb_pkg::CELL_W'(cell_full);
      out_code_q    <= job_q.vcode[i_q] + job_q.hcode[j_q];
      out_clamped_q <= job_q.clamped;
      out_last_q    <= last_cell;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.out_particle_id = out_pid_q;
  assign out_o.cell_index      = out_cell_q;
  assign out_o.wrap_code       = out_code_q;
  assign out_o.span_clamped    = out_clamped_q;
  assign out_o.last            = out_last_q;

  a_cursor_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (i_q <= job_q.rcnt) && (j_q <= job_q.ccnt))
    else $error("cursor left the box");

  a_cursor_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> ((IW+1)'(row_q) < (IW+1)'(job_q.nr)) &&
               ((IW+1)'(col_q) < (IW+1)'(job_q.nc)))
    else $error("wrapped cursor outside the grid");

  a_last_ends_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && last_cell |=> !busy_q)
    else $error("job still busy after its last cell");

endmodule

FILE: hw/rtl/torus_spatial_hash_binning.sv
// Top level of the torus spatial hash binning block: config registers, front, queue, back.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    particle_id, pos_x, pos_y, radius
//   out_o    out  valid/ready    out_particle_id, cell_index, wrap_code, span_clamped, last
//   cfg_i    in   valid/ready    index, data (ready always high)
//
// The front end works on one item at a time: accept, four cell edges of multiply then sum,
// a clamp step, five 8-bit steps of the shared-width remainder units, one queue push.
// The back end registers a job, then emits its cells (1 to 9) one per cycle unless stalled.
// A two-entry job queue lets the front work on the next item while the back stalls.
// Reset is asynchronous, active low; no clearing pass is needed.
module torus_spatial_hash_binning (
  input  logic        clk_i,
  input  logic        rst_ni,
  tshb_in_if.sink     in_i,
  tshb_out_if.source  out_o,
  tshb_cfg_if.sink    cfg_i
);

  logic signed [tshb_pkg::COORD_W-1:0] x_origin_q, y_origin_q;
  logic [tshb_pkg::SCALE_W-1:0]        x_scale_q, y_scale_q;
  logic [tshb_pkg::NUM_W-1:0]          num_rows_q, num_cols_q;

  tshb_pkg::cfg_t cfg_w;
  tshb_pkg::job_t front_job, fifo_job;
  logic           push, full, pop, avail;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_origin_q <= '0;
      y_origin_q <= '0;
      x_scale_q  <= tshb_pkg::SCALE_RST;
      y_scale_q  <= tshb_pkg::SCALE_RST;
      num_rows_q <= tshb_pkg::NUM_RST;
      num_cols_q <= tshb_pkg::NUM_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (tshb_pkg::cfg_reg_e'(cfg_i.index))
        tshb_pkg::REG_X_ORIGIN: x_origin_q <= $signed(cfg_i.data[tshb_pkg::COORD_W-1:0]);
        tshb_pkg::REG_Y_ORIGIN: y_origin_q <= $signed(cfg_i.data[tshb_pkg::COORD_W-1:0]);
        tshb_pkg::REG_X_SCALE:  x_scale_q  <= cfg_i.data[tshb_pkg::SCALE_W-1:0];
        tshb_pkg::REG_Y_SCALE:  y_scale_q  <= cfg_i.data[tshb_pkg::SCALE_W-1:0];
        tshb_pkg::REG_NUM_ROWS: num_rows_q <= cfg_i.data[tshb_pkg::NUM_W-1:0];
        tshb_pkg::REG_NUM_COLS: num_cols_q <= cfg_i.data[tshb_pkg::NUM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_w.x_origin = x_origin_q;
    cfg_w.y_origin = y_origin_q;
    cfg_w.x_scale  = x_scale_q;
    cfg_w.y_scale  = y_scale_q;
    cfg_w.nr       = tshb_pkg::dim_of(num_rows_q);
    cfg_w.nc       = tshb_pkg::dim_of(num_cols_q);
  end

  tshb_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_w),
    .push_o (push),
    .job_o  (front_job),
    .full_i (full)
  );

  tshb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_job),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .data_o  (fifo_job)
  );

  tshb_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .job_i   (fifo_job),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

FILE: dv/torus_spatial_hash_binning_tb.sv
// Testbench for torus_spatial_hash_binning: directed and random particles checked against a predictor.
module torus_spatial_hash_binning_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 24;

  typedef struct {
    logic [tshb_pkg::PID_W-1:0]  pid;
    logic [tshb_pkg::CELL_W-1:0] cell_idx;
    tshb_pkg::code_t             code;
    logic                        clamped;
    logic                        last;
  } cell_hit_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic hold_out = 1'b0;

  tshb_in_if  particle_ch ();
  tshb_out_if cell_ch ();
  tshb_cfg_if cfg_ch ();

  torus_spatial_hash_binning u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (particle_ch),
    .out_o  (cell_ch),
    .cfg_i  (cfg_ch)
  );

  // register shadows, reset values
  logic signed [tshb_pkg::COORD_W-1:0] x_org = '0;
  logic signed [tshb_pkg::COORD_W-1:0] y_org = '0;
  logic [tshb_pkg::SCALE_W-1:0]        x_scl = 32'h0001_0000;
  logic [tshb_pkg::SCALE_W-1:0]        y_scl = 32'h0001_0000;
  logic [tshb_pkg::NUM_W-1:0]          n_rows = 9'd1;
  logic [tshb_pkg::NUM_W-1:0]          n_cols = 9'd1;

  longint    world_w = 64'h1_0000;
  longint    world_h = 64'h1_0000;
  cell_hit_t cells_due[$];
  int        mismatch_count = 0;
  int        src_idle_pct = 0;
  int        snk_idle_pct = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic flag_error(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic longint grid_dim(input logic [tshb_pkg::NUM_W-1:0] n);
    if (n == '0) begin
      return 1;
    end else if (n > tshb_pkg::MAX_DIM) begin
      return tshb_pkg::MAX_DIM;
    end
    return n;
  endfunction

  // floor(diff * scale / 2^32), exact
  function automatic longint cell_of(input longint diff,
                                     input logic [tshb_pkg::SCALE_W-1:0] scale);
    logic signed [71:0] d;
    logic signed [71:0] s;
    logic signed [71:0] p;
    d = diff;
    s = {40'd0, scale};
    p = d * s;
    return longint'(p >>> 32);
  endfunction

  function automatic longint wrap_to(input longint r, input longint n);
    longint m;
    m = r % n;
    if (m < 0) begin
      m += n;
    end
    return m;
  endfunction

  function automatic void bin_particle(input logic [tshb_pkg::PID_W-1:0] id,
                                       input logic signed [tshb_pkg::COORD_W-1:0] px,
                                       input logic signed [tshb_pkg::COORD_W-1:0] py,
                                       input logic [tshb_pkg::RAD_W-1:0] rad);
    longint          nr, nc, r0, r1, c0, c1, span, r, c, row, col;
    logic            clamped;
    tshb_pkg::code_t vcode, hcode;
    cell_hit_t       hit;
    nr   = grid_dim(n_rows);
    nc   = grid_dim(n_cols);
    span = tshb_pkg::MAX_SPAN;
    r0 = cell_of(longint'(py) - longint'(rad) - longint'(y_org), y_scl);
    r1 = cell_of(longint'(py) + longint'(rad) - longint'(y_org), y_scl);
    c0 = cell_of(longint'(px) - longint'(rad) - longint'(x_org), x_scl);
    c1 = cell_of(longint'(px) + longint'(rad) - longint'(x_org), x_scl);
    clamped = 1'b0;
    if (r1 - r0 + 1 > span) begin
      r1 = r0 + span - 1;
      clamped = 1'b1;
    end
    if (c1 - c0 + 1 > span) begin
      c1 = c0 + span - 1;
      clamped = 1'b1;
    end
    for (r = r0; r <= r1; r++) begin
      if (r < 0) begin
        vcode = tshb_pkg::WRAP_UP;
      end else if (r >= nr) begin
        vcode = tshb_pkg::WRAP_DOWN;
      end else begin
        vcode = tshb_pkg::WRAP_NONE;
      end
      row = wrap_to(r, nr);
      for (c = c0; c <= c1; c++) begin
        if (c < 0) begin
          hcode = tshb_pkg::WRAP_RIGHT;
        end else if (c >= nc) begin
          hcode = tshb_pkg::WRAP_LEFT;
        end else begin
          hcode = tshb_pkg::WRAP_NONE;
        end
        col = wrap_to(c, nc);
        hit.pid      = id;
        hit.cell_idx = tshb_pkg::CELL_W'(row * nc + col);
        hit.code     = vcode + hcode;
        hit.clamped  = clamped;
        hit.last     = (r == r1) && (c == c1);
        cells_due = {cells_due, hit};
      end
    end
  endfunction

  task automatic write_reg(input tshb_pkg::cfg_reg_e idx,
                           input logic [tshb_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      tshb_pkg::REG_X_ORIGIN: x_org = data;
      tshb_pkg::REG_Y_ORIGIN: y_org = data;
      tshb_pkg::REG_X_SCALE:  x_scl = data;
      tshb_pkg::REG_Y_SCALE:  y_scl = data;
      tshb_pkg::REG_NUM_ROWS: n_rows = data[tshb_pkg::NUM_W-1:0];
      tshb_pkg::REG_NUM_COLS: n_cols = data[tshb_pkg::NUM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] xo, input logic [31:0] yo,
                           input logic [31:0] xs, input logic [31:0] ys,
                           input logic [tshb_pkg::NUM_W-1:0] nr,
                           input logic [tshb_pkg::NUM_W-1:0] nc);
    write_reg(tshb_pkg::REG_X_ORIGIN, xo);
    write_reg(tshb_pkg::REG_Y_ORIGIN, yo);
    write_reg(tshb_pkg::REG_X_SCALE, xs);
    write_reg(tshb_pkg::REG_Y_SCALE, ys);
    write_reg(tshb_pkg::REG_NUM_ROWS, 32'(nr));
    write_reg(tshb_pkg::REG_NUM_COLS, 32'(nc));
    cfg_ch.valid <= 1'b0;
  endtask

  // stop offering particles and wait until every cell is out
  task automatic settle();
    particle_ch.valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_particle(input logic [tshb_pkg::PID_W-1:0] id,
                               input logic signed [tshb_pkg::COORD_W-1:0] px,
                               input logic signed [tshb_pkg::COORD_W-1:0] py,
                               input logic [tshb_pkg::RAD_W-1:0] rad);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      particle_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    particle_ch.valid       <= 1'b1;
    particle_ch.particle_id <= id;
    particle_ch.pos_x       <= px;
    particle_ch.pos_y       <= py;
    particle_ch.radius      <= rad;
    do @(posedge clk_i); while (!particle_ch.ready);
    bin_particle(id, px, py, rad);
  endtask

  function automatic logic [tshb_pkg::NUM_W-1:0] pick_dim();
    if ($urandom_range(0, 7) == 0) begin
      return tshb_pkg::NUM_W'($urandom_range(0, 511));
    end
    return tshb_pkg::NUM_W'($urandom_range(1, 16));
  endfunction

  task automatic randomize_grid();
    logic [tshb_pkg::NUM_W-1:0] nr, nc;
    logic [31:0]                xs, ys;
    nr = pick_dim();
    nc = pick_dim();
    world_w = longint'($urandom_range(1, 32)) << 16;
    world_h = longint'($urandom_range(1, 32)) << 16;
    xs = 32'((grid_dim(nc) << 32) / world_w);
    ys = 32'((grid_dim(nr) << 32) / world_h);
    if ($urandom_range(0, 5) == 0) begin
      xs = $urandom;
    end
    if ($urandom_range(0, 5) == 0) begin
      ys = $urandom;
    end
    configure(32'(int'($urandom) >>> 6), 32'(int'($urandom) >>> 6), xs, ys, nr, nc);
  endtask

  // mostly particles in or near the world with radius up to a cell (at times four), some pure noise
  task automatic send_random_particle();
    longint cw, ch, px, py, rmax;
    if ($urandom_range(0, 99) < 12) begin
      send_particle(tshb_pkg::PID_W'($urandom), $urandom, $urandom,
                    tshb_pkg::RAD_W'($urandom));
    end else begin
      cw = world_w / grid_dim(n_cols);
      ch = world_h / grid_dim(n_rows);
      px = longint'(x_org) - cw + $urandom_range(0, 32'(world_w + 2 * cw));
      py = longint'(y_org) - ch + $urandom_range(0, 32'(world_h + 2 * ch));
      rmax = (cw < ch) ? cw : ch;
      if ($urandom_range(0, 3) == 0) begin
        rmax = 4 * rmax;
      end
      send_particle(tshb_pkg::PID_W'($urandom), 32'(px), 32'(py),
                    tshb_pkg::RAD_W'($urandom_range(0, 32'(rmax))));
    end
  endtask

  task automatic test_reset_grid();
    send_particle(16'h0001, 32'sh0000_8000, 32'sh0000_8000, 31'h0);
    send_particle(16'h0002, 32'shFFFC_CCCD, 32'sh0005_B333, 31'h0000_6666);
    send_particle(16'h0003, 32'sh0000_0000, 32'sh0000_0000, 31'h0001_0000);
  endtask

  task automatic test_wrap_codes();
    settle();
    configure(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 9'd8, 9'd8);
    send_particle(16'h0010, 32'sh0004_8000, 32'sh0004_8000, 31'h0);
    // corners reach all four wrap sides
    send_particle(16'h0011, 32'sh0000_3333, 32'sh0000_3333, 31'h0000_8000);
    send_particle(16'h0012, 32'sh0007_CCCD, 32'sh0007_CCCD, 31'h0000_8000);
    send_particle(16'h0013, 32'sh0007_CCCD, 32'sh0000_3333, 31'h0000_8000);
    send_particle(16'h0014, 32'sh0000_3333, 32'sh0007_CCCD, 31'h0000_8000);
    // far outside the world
    send_particle(16'h0015, 32'sh0064_8000, 32'shFFCD_8000, 31'h0);
    // long span on both axes
    send_particle(16'h0016, 32'sh0004_0000, 32'sh0004_0000, 31'h0003_0000);
    // exactly on cell edges
    send_particle(16'h0017, 32'sh0004_0000, 32'sh0004_0000, 31'h0);
    send_particle(16'h0018, 32'sh0004_0000, 32'sh0004_0000, 31'h0001_0000);
  endtask

  task automatic test_field_extremes();
    send_particle(16'hFFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF);
    send_particle(16'h0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h0);
    send_particle(16'h5A5A, 32'sh0, 32'sh0, 31'h1);
  endtask

  task automatic test_grid_limits();
    settle();
    // zero rows, full width, zero and maximum scale, extreme origins
    configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 9'd0, 9'd256);
    send_particle(16'h0020, 32'sh1234_5678, 32'sh0000_0000, 31'h0000_4000);
    send_particle(16'h0021, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h0);
    send_particle(16'h0022, 32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF);
    settle();
    // oversized grid counts; only the column span clamps
    configure(32'h0, 32'h0, 32'h0004_0000, 32'h0001_0000, 9'd511, 9'd300);
    send_particle(16'h0023, 32'sh0010_0000, 32'sh0010_8000, 31'h0000_999A);
    send_particle(16'h0024, 32'sh00FF_C000, 32'sh01FF_8000, 31'h0000_2000);
    send_particle(16'h0025, 32'shFFFF_F000, 32'shFFFF_F000, 31'h0000_1000);
  endtask

  task automatic test_random_traffic(input int n_items, input int per_grid);
    for (int i = 0; i < n_items; i++) begin
      if (i % per_grid == 0) begin
        settle();
        randomize_grid();
      end
      send_random_particle();
    end
  endtask

  // hold the output off while particles keep coming, so the input backs up
  task automatic test_output_stall();
    settle();
    world_w = 64'h10_0000;
    world_h = 64'h10_0000;
    configure(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 9'd16, 9'd16);
    fork
      begin
        hold_out <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_out <= 1'b0;
      end
      repeat (20) send_random_particle();
    join
  endtask

  initial begin : cell_checker
    cell_hit_t want;
    cell_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && cell_ch.valid && cell_ch.ready) begin
        if (cells_due.size() == 0) begin
          flag_error($sformatf("unexpected cell %0d for particle %0d",
                               cell_ch.cell_index, cell_ch.out_particle_id));
        end else begin
          want = cells_due.pop_front();
          if (cell_ch.out_particle_id !== want.pid) begin
            flag_error($sformatf("particle id: expected %0d got %0d",
                                 want.pid, cell_ch.out_particle_id));
          end
          if (cell_ch.cell_index !== want.cell_idx) begin
            flag_error($sformatf("cell index (particle %0d): expected %0d got %0d",
                                 want.pid, want.cell_idx, cell_ch.cell_index));
          end
          if (cell_ch.wrap_code !== want.code) begin
            flag_error($sformatf("wrap code (particle %0d, cell %0d): expected %0d got %0d",
                                 want.pid, want.cell_idx, want.code, cell_ch.wrap_code));
          end
          if (cell_ch.span_clamped !== want.clamped) begin
            flag_error($sformatf("span clamped (particle %0d): expected %0b got %0b",
                                 want.pid, want.clamped, cell_ch.span_clamped));
          end
          if (cell_ch.last !== want.last) begin
            flag_error($sformatf("last (particle %0d, cell %0d): expected %0b got %0b",
                                 want.pid, want.cell_idx, want.last, cell_ch.last));
          end
        end
      end
      cell_ch.ready <= !hold_out && ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((particle_ch.valid && particle_ch.ready) || (cell_ch.valid && cell_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[%0t] ERROR: no item moved for %0d cycles", $realtime, STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    particle_ch.valid       <= 1'b0;
    particle_ch.particle_id <= '0;
    particle_ch.pos_x       <= '0;
    particle_ch.pos_y       <= '0;
    particle_ch.radius      <= '0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.index            <= '0;
    cfg_ch.data             <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 15;
    snk_idle_pct = 45;
    test_reset_grid();
    test_wrap_codes();
    test_field_extremes();
    test_grid_limits();
    test_random_traffic(45, 15);

    src_idle_pct = 0;
    test_output_stall();

    src_idle_pct = 45;
    snk_idle_pct = 15;
    test_random_traffic(45, 15);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_traffic(45, 15);

    settle();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/tshb_pkg.sv
hw/rtl/tshb_in_if.sv
hw/rtl/tshb_out_if.sv
hw/rtl/tshb_cfg_if.sv
hw/rtl/tshb_front.sv
hw/rtl/tshb_fifo.sv
hw/rtl/tshb_back.sv
hw/rtl/torus_spatial_hash_binning.sv
dv/torus_spatial_hash_binning_tb.sv
